### rtl/sha256_stream_hasher_top_assert.svh
// Assertion macros used by the hasher core.
`ifndef SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_STREAM_HASHER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SHASH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hasher check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SHASH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hasher check failed");

`endif

### rtl/shash_pkg.sv
// Types, constants and helper functions shared by the SHA-256 hasher.
`timescale 1ns / 1ps
`default_nettype none
package shash_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  byte_count;
    logic        last_item;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } out_item_t;

  // Block store write request from the byte packer.
  typedef struct packed {
    logic        we;
    logic [3:0]  addr;
    logic [31:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic start;
    logic reinit;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
  } core_stat_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_LOAD,
    C_RUN,
    C_FOLD
  } core_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BYTE,
    S_PAD,
    S_LEN_HI,
    S_LEN_LO,
    S_WAIT,
    S_OUT
  } top_state_t;

  localparam logic [2:0] PH_ADDR  = 3'd0;
  localparam logic [2:0] PH_CAP0  = 3'd1;
  localparam logic [2:0] PH_CAP1  = 3'd2;
  localparam logic [2:0] PH_SCHED = 3'd3;
  localparam logic [2:0] PH_ROUND = 3'd4;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [3:0] LEN_HI_WORD = 4'd14;
  localparam logic [3:0] LEN_LO_WORD = 4'd15;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  // Replace one byte lane of a word; lane 0 is bits 31 to 24.
  function automatic logic [31:0] put_lane(input logic [31:0] w, input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = w;
    case (lane)
      2'd0: r[31:24] = b;
      2'd1: r[23:16] = b;
      2'd2: r[15:8]  = b;
      default: r[7:0] = b;
    endcase
    put_lane = r;
  endfunction

endpackage
`default_nettype wire

### rtl/shash_core.sv
// Compression engine: block store memory, rolling schedule and round registers.
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_stream_hasher_top_assert.svh"
module shash_core import shash_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  core_ctrl_t  ctrl,
  input  mem_wr_t     wr,
  input  logic [2:0]  hash_sel,
  output core_stat_t  stat,
  output logic [31:0] hash_word
);

  logic [31:0] block_mem [16];
  logic [31:0] rd_a, rd_b;
  logic [3:0]  raddr_a, raddr_b;
  logic        mem_we;
  logic [3:0]  mem_waddr;
  logic [31:0] mem_wdata;

  core_state_t state, state_next;
  logic [2:0]  phase;
  logic [5:0]  round;
  logic [31:0] hash [8];
  logic [31:0] rr [8];
  logic [31:0] wt, w1, w9, w14, w_reg;
  logic [31:0] w_sched, t1, t2, ch, maj;

  // Schedule word for this round.
  assign w_sched = round[5:4] == 2'd0 ? wt : wt + sig0(w1) + w9 + sig1(w14);

  // Round functions.
  assign ch  = (rr[4] & rr[5]) ^ (~rr[4] & rr[6]);
  assign maj = (rr[0] & rr[1]) ^ (rr[0] & rr[2]) ^ (rr[1] & rr[2]);
  assign t1  = rr[7] + bsig1(rr[4]) + ch + ROUND_K[round] + w_reg;
  assign t2  = bsig0(rr[0]) + maj;

  // Read addresses: current word and its neighbour, then the two far taps.
  always_comb begin
    if (phase == PH_ADDR) begin
      raddr_a = round[3:0];
      raddr_b = round[3:0] + 4'd1;
    end else begin
      raddr_a = round[3:0] + 4'd9;
      raddr_b = round[3:0] + 4'd14;
    end
  end

  // Write port: schedule write-back during a run, otherwise the byte packer.
  always_comb begin
    if (state == C_RUN) begin
      mem_we    = (phase == PH_SCHED) && (round[5:4] != 2'd0);
      mem_waddr = round[3:0];
      mem_wdata = w_sched;
    end else begin
      mem_we    = wr.we;
      mem_waddr = wr.addr;
      mem_wdata = wr.data;
    end
  end

  // Block store with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      block_mem[mem_waddr] <= mem_wdata;
    end
    rd_a <= block_mem[raddr_a];
    rd_b <= block_mem[raddr_b];
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      C_IDLE: if (ctrl.start) state_next = C_LOAD;
      C_LOAD: state_next = C_RUN;
      C_RUN: begin
        if (phase == PH_ROUND && round == 6'd63) state_next = C_FOLD;
      end
      C_FOLD: state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Phase and round counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_ADDR;
      round <= '0;
    end else if (state == C_LOAD) begin
      phase <= PH_ADDR;
      round <= '0;
    end else if (state == C_RUN) begin
      if (phase == PH_ROUND) begin
        phase <= PH_ADDR;
        round <= round + 6'd1;
      end else begin
        phase <= phase + 3'd1;
      end
    end
  end

  // Operand capture and the round itself.
  always_ff @(posedge clk) begin
    if (state == C_LOAD) begin
      for (int j = 0; j < 8; j++) rr[j] <= hash[j];
    end else if (state == C_RUN) begin
      case (phase)
        PH_CAP0: begin
          wt <= rd_a;
          w1 <= rd_b;
        end
        PH_CAP1: begin
          w9  <= rd_a;
          w14 <= rd_b;
        end
        PH_SCHED: w_reg <= w_sched;
        PH_ROUND: begin
          rr[1] <= rr[0];
          rr[2] <= rr[1];
          rr[3] <= rr[2];
          rr[5] <= rr[4];
          rr[6] <= rr[5];
          rr[7] <= rr[6];
          rr[4] <= rr[3] + t1;
          rr[0] <= t1 + t2;
        end
        default: ;
      endcase
    end
  end

  // Chaining value: initial hash, folded after every block, back to the initial hash on reinit.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 8; j++) hash[j] <= HASH_IV[j];
    end else if (state == C_FOLD) begin
      for (int j = 0; j < 8; j++) hash[j] <= hash[j] + rr[j];
    end else if (ctrl.reinit) begin
      for (int j = 0; j < 8; j++) hash[j] <= HASH_IV[j];
    end
  end

  assign stat.busy = state != C_IDLE;
  assign hash_word = hash[hash_sel];

  `SHASH_ASSERT_NOW(a_start_idle, ctrl.start, state == C_IDLE)
  `SHASH_ASSERT_NOW(a_phase_range, state == C_RUN, phase <= PH_ROUND)
  `SHASH_ASSERT_NEXT(a_fold_idle, state == C_FOLD, state == C_IDLE && round == 6'd0)

endmodule
`default_nettype wire

### rtl/sha256_stream_hasher_top.sv
// Top level of the SHA-256 stream hasher: byte packing, padding and digest output.
//
//  channel | direction | payload     | handshake
//  in      | input     | in_item_t   | in_valid / in_stall
//  out     | output    | out_item_t  | out_valid / out_stall
//
// A request is taken in S_IDLE, its bytes are packed in S_BYTE and a final S_BYTE
// step closes it. Every 64 bytes the engine loads the round registers, runs 64
// rounds, each through the address, two capture, schedule and round phases set by
// the two-port block store reads of the schedule taps, and folds the result, while
// requests wait. Bytes and padding pack one a cycle while the engine is idle,
// and the eight digest words leave one a cycle while the output is not stalled.
// rst is synchronous; after it the hash holds the initial value and no item is open.
// A stalled output holds its word; new requests wait until the last word is loaded.
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher_top import shash_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  top_state_t  state, state_next, ret_state;
  logic [63:0] byte_total;
  logic [31:0] item_word;
  logic [2:0]  cnt;
  logic        last;
  logic [31:0] acc, acc_new;
  logic [5:0]  pad_pos;
  logic        pad_first;
  logic [2:0]  out_idx;
  logic        out_load;
  logic [5:0]  cur_pos;
  logic [7:0]  cur_byte;

  core_ctrl_t  ctrl;
  core_stat_t  stat;
  mem_wr_t     wr;
  logic [31:0] hash_word;

  shash_core u_core (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .wr        (wr),
    .hash_sel  (out_idx),
    .stat      (stat),
    .hash_word (hash_word)
  );

  assign in_stall = state != S_IDLE;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  // Byte being packed and its block position.
  assign cur_pos  = state == S_PAD ? pad_pos : byte_total[5:0];
  assign cur_byte = state == S_PAD ? (pad_first ? PAD_BYTE : 8'h00) : item_word[31:24];
  assign acc_new  = put_lane(acc, cur_pos[1:0], cur_byte);

  // Next state, store writes and engine control.
  always_comb begin
    state_next  = state;
    ctrl.start  = 1'b0;
    ctrl.reinit = 1'b0;
    wr.we       = 1'b0;
    wr.addr     = cur_pos[5:2];
    wr.data     = acc_new;
    case (state)
      S_IDLE: if (in_valid) state_next = S_BYTE;
      S_BYTE: begin
        if (cnt == 3'd0) begin
          state_next = last ? S_PAD : S_IDLE;
        end else begin
          wr.we = cur_pos[1:0] == 2'd3;
          if (cur_pos == 6'd63) begin
            ctrl.start = 1'b1;
            state_next = S_WAIT;
          end
        end
      end
      S_PAD: begin
        wr.we = cur_pos[1:0] == 2'd3;
        if (cur_pos == 6'd63) begin
          ctrl.start = 1'b1;
          state_next = S_WAIT;
        end else if (cur_pos + 6'd1 == LEN_POS) begin
          state_next = S_LEN_HI;
        end
      end
      S_LEN_HI: begin
        wr.we      = 1'b1;
        wr.addr    = LEN_HI_WORD;
        wr.data    = byte_total[60:29];
        state_next = S_LEN_LO;
      end
      S_LEN_LO: begin
        wr.we      = 1'b1;
        wr.addr    = LEN_LO_WORD;
        wr.data    = {byte_total[28:0], 3'b000};
        ctrl.start = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: if (!stat.busy) state_next = ret_state;
      S_OUT: begin
        if (out_load && out_idx == 3'd7) begin
          ctrl.reinit = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers: byte count, return point and output index.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_total <= '0;
      ret_state  <= S_IDLE;
      out_idx    <= '0;
      out_valid  <= 1'b0;
      cnt        <= '0;
      pad_first  <= 1'b0;
      pad_pos    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) cnt <= in_data.byte_count > 3'd4 ? 3'd4 : in_data.byte_count;
        end
        S_BYTE: begin
          if (cnt == 3'd0) begin
            pad_pos   <= byte_total[5:0];
            pad_first <= 1'b1;
          end else begin
            cnt        <= cnt - 3'd1;
            byte_total <= byte_total + 64'd1;
            ret_state  <= S_BYTE;
          end
        end
        S_PAD: begin
          pad_pos   <= pad_pos + 6'd1;
          pad_first <= 1'b0;
          ret_state <= S_PAD;
        end
        S_LEN_LO: ret_state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) byte_total <= '0;
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      item_word <= in_data.message_word;
      last      <= in_data.last_item;
    end else if (state == S_BYTE && cnt != 3'd0) begin
      item_word <= {item_word[23:0], 8'h00};
    end
    if ((state == S_BYTE && cnt != 3'd0) || state == S_PAD) begin
      acc <= acc_new;
    end
    if (out_load) begin
      out_data.digest_word <= hash_word;
      out_data.digest_last <= out_idx == 3'd7;
    end
  end

endmodule
`default_nettype wire

### verif/sha256_stream_hasher_top_tb.sv
// Self-checking testbench for the SHA-256 stream hasher top level.
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher_top_tb;
  import shash_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  sha256_stream_hasher_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predictor state: running hash, block buffer and byte count.
  logic [31:0] hash_state [8];
  logic [31:0] block_buf [16];
  logic [63:0] msg_bytes;

  in_item_t  pending_requests [$];
  out_item_t expected_digest [$];

  int  sender_idle_pct;
  int  receiver_idle_pct;
  bit  hold_receiver;
  bit  stimulus_done;
  int  fail_count;
  int  digest_count;
  int  request_count;
  longint cycle_count;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One SHA-256 compression of the block buffer into the running hash.
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) w[t] = block_buf[t];
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[t] + w[t];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  function automatic void place_byte(input int pos, input logic [7:0] val);
    int sh;
    sh = 24 - 8 * (pos % 4);
    block_buf[pos / 4] = (block_buf[pos / 4] & ~(32'hFF << sh)) | (32'(val) << sh);
  endfunction

  // Absorbs one request and, on a last request, queues the eight digest words.
  function automatic void absorb_request(input in_item_t req);
    int n, pos;
    logic [63:0] bit_len;
    out_item_t r;
    n = (req.byte_count > 4) ? 4 : int'(req.byte_count);
    for (int i = 0; i < n; i++) begin
      pos = int'(msg_bytes[5:0]);
      place_byte(pos, req.message_word[31 - 8 * i -: 8]);
      msg_bytes++;
      if (pos == 63) compress_block();
    end
    if (!req.last_item) return;
    pos = int'(msg_bytes[5:0]);
    bit_len = msg_bytes << 3;
    place_byte(pos, PAD_BYTE);
    pos++;
    if (pos > 56) begin
      for (int p = pos; p < 64; p++) place_byte(p, 8'h00);
      compress_block();
      pos = 0;
    end
    for (int p = pos; p < 56; p++) place_byte(p, 8'h00);
    block_buf[14] = bit_len[63:32];
    block_buf[15] = bit_len[31:0];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      r.digest_word = hash_state[i];
      r.digest_last = (i == 7);
      expected_digest.push_back(r);
    end
    for (int i = 0; i < 8; i++) hash_state[i] = HASH_IV[i];
    msg_bytes = '0;
  endfunction

  function automatic in_item_t make_request(input logic [31:0] w, input int cnt,
                                            input bit lst);
    in_item_t q;
    q.message_word = w;
    q.byte_count   = 3'(cnt);
    q.last_item    = lst;
    return q;
  endfunction

  // Queues a message of nwords random words whose tail carries tail_cnt bytes.
  task automatic queue_message(input int nwords, input int tail_cnt);
    for (int i = 0; i < nwords; i++)
      pending_requests.push_back(make_request($urandom, 4, 1'b0));
    pending_requests.push_back(make_request($urandom, tail_cnt, 1'b1));
  endtask

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Request driver: holds a stalled request, idles at random otherwise.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) absorb_request(in_data);
      if (in_valid) request_count++;
      if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_data  <= pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Digest monitor and receiver stall generation.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        digest_count++;
        if (expected_digest.size() == 0) begin
          $display("%0t: unexpected digest word %h last %b", $time,
                   out_data.digest_word, out_data.digest_last);
          fail_count++;
        end else begin
          out_item_t ex;
          ex = expected_digest.pop_front();
          if (ex.digest_word !== out_data.digest_word ||
              ex.digest_last !== out_data.digest_last) begin
            $display("%0t: digest mismatch, expected %h/%b, got %h/%b", $time,
                     ex.digest_word, ex.digest_last, out_data.digest_word,
                     out_data.digest_last);
            fail_count++;
          end
        end
      end
      out_stall <= hold_receiver || ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Long receiver hold-off, counted in its own process.
  initial begin
    hold_receiver = 1'b0;
    wait (request_count >= 150);
    hold_receiver = 1'b1;
    repeat (3000) @(posedge clk);
    hold_receiver = 1'b0;
  end

  task automatic wait_drained();
    while (pending_requests.size() > 0 || in_valid || expected_digest.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int nw;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b1;
    fail_count = 0;
    digest_count = 0;
    request_count = 0;
    cycle_count = 0;
    stimulus_done = 1'b0;
    msg_bytes = '0;
    for (int i = 0; i < 8; i++) hash_state[i] = HASH_IV[i];
    for (int i = 0; i < 16; i++) block_buf[i] = '0;
    sender_idle_pct = 33;
    receiver_idle_pct = 75;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty message, short tails, saturating counts, padding edges.
    pending_requests.push_back(make_request(32'hFFFF_FFFF, 0, 1'b1));
    pending_requests.push_back(make_request(32'h6162_6300, 3, 1'b1));
    pending_requests.push_back(make_request(32'hFFFF_FFFF, 7, 1'b1));
    pending_requests.push_back(make_request(32'h0000_0000, 5, 1'b0));
    pending_requests.push_back(make_request(32'hA5A5_A5A5, 1, 1'b0));
    pending_requests.push_back(make_request(32'h5A5A_5A5A, 6, 1'b1));
    pending_requests.push_back(make_request(32'h1234_5678, 2, 1'b0));
    pending_requests.push_back(make_request(32'h9ABC_DEF0, 4, 1'b1));
    queue_message(13, 3);
    queue_message(15, 0);

    // Random messages, mostly well-formed with occasional short inner words.
    for (int phase = 0; phase < 3; phase++) begin
      while (pending_requests.size() < 100) begin
        nw = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(18);
        for (int i = 0; i < nw; i++)
          pending_requests.push_back(make_request($urandom,
            ($urandom_range(7) == 0) ? $urandom_range(7) : 4, 1'b0));
        pending_requests.push_back(make_request($urandom, $urandom_range(7), 1'b1));
      end
      wait_drained();
      if (phase == 0) begin
        sender_idle_pct = 75; receiver_idle_pct = 33;
      end else begin
        sender_idle_pct = 0; receiver_idle_pct = 0;
      end
    end
    repeat (400) @(posedge clk);
    $display("Sent %0d requests and checked %0d digest words across three idling phases.",
             request_count, digest_count);
    if (fail_count == 0 && expected_digest.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
